// ----- src/b4gd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b4gd_pkg: shared types, constants and fp helpers
// Floating point building blocks for the bf16 x int4 lookup group dot product:
// bf16 multiply with flush, a generic align/add/round core and fp32 packing.
// ----------------------------------------------------------------------------
package b4gd_pkg;

  localparam int LANES       = 16;
  localparam int GROUP       = 32;
  localparam int ACT_W       = 16;
  localparam int CODE_W      = 4;
  localparam int REG_W       = 64;
  localparam int NUM_REGS    = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CODE_LSB    = GROUP * ACT_W;
  localparam int SCALE_LSB   = CODE_LSB + GROUP * CODE_W;
  localparam int S_DATA_W    = SCALE_LSB + ACT_W;
  localparam int RED_LEVELS  = 4;

  localparam logic [31:0] QNAN   = 32'h7FC0_0000;
  localparam logic [7:0]  EXP_MAX = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_PROD,
    ST_ACC,
    ST_LOAD,
    ST_RED,
    ST_OUT
  } state_t;

  // stage strobes from the sequencer to every lane
  typedef struct packed {
    logic mul_en;
    logic sum_en;
    logic prod_en;
    logic acc_en;
    logic acc_clr;
  } lane_ctrl_t;

  // operand in extended form: value = mant * 2^(exp - 127 - 62)
  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               sign;
    logic signed [11:0] exp;
    logic [63:0]        mant;
  } xfp_t;

  // leading zero count
  function automatic logic [6:0] lzc64(input logic [63:0] m);
    logic [6:0] n;
    logic       found;
    n     = 7'd64;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && m[i]) begin
        n     = 7'(63 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // right shift, lost bits jammed into bit 0
  function automatic logic [63:0] shr_jam(input logic [63:0] m, input logic [11:0] sh);
    logic [63:0] r;
    logic [63:0] mask;
    logic        st;
    if (sh >= 12'd64) begin
      r  = '0;
      st = |m;
    end else begin
      r    = m >> sh[5:0];
      mask = ~(64'hFFFF_FFFF_FFFF_FFFF << sh[5:0]);
      st   = |(m & mask);
    end
    return r | {63'd0, st};
  endfunction

  // round to nearest even and pack; value = m * 2^(e - 127 - 63)
  function automatic logic [31:0] rnd_pack(input logic sign, input logic signed [11:0] e,
                                           input logic [63:0] m);
    logic [6:0]         lz;
    logic [63:0]        mn;
    logic signed [12:0] en;
    logic [23:0]        kept;
    logic               g;
    logic               st;
    logic               inc;
    logic [7:0]         base;
    logic [31:0]        tot;
    if (m == 64'd0) return {sign, 31'd0};
    lz = lzc64(m);
    mn = m << lz;
    en = 13'(e) - 13'(lz);
    if (en >= 13'sd255) return {sign, EXP_MAX, 23'd0};
    if (en <= 13'sd0) begin
      mn   = shr_jam(mn, 12'(13'sd1 - en));
      base = 8'd0;
    end else begin
      base = 8'(en - 13'sd1);
    end
    kept = mn[63:40];
    g    = mn[39];
    st   = |mn[38:0];
    inc  = g & (st | kept[0]);
    tot  = {1'b0, base, 23'd0} + {8'd0, kept} + {31'd0, inc};
    return {sign, tot[30:0]};
  endfunction

  // fp32 into extended form (subnormals keep exponent 1, no hidden bit)
  function automatic xfp_t unpack32(input logic [31:0] x);
    xfp_t r;
    logic [7:0] eff;
    eff    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    r.sign = x[31];
    r.nan  = (x[30:23] == EXP_MAX) && (x[22:0] != 23'd0);
    r.inf  = (x[30:23] == EXP_MAX) && (x[22:0] == 23'd0);
    r.exp  = $signed({4'b0, eff});
    r.mant = {1'b0, (x[30:23] != 8'd0), x[22:0], 39'd0};
    return r;
  endfunction

  // bring mantissa msb to bit 62
  function automatic xfp_t norm62(input xfp_t x);
    xfp_t       r;
    logic [6:0] lz;
    logic [6:0] sh;
    r = x;
    if (x.mant != 64'd0) begin
      lz     = lzc64(x.mant);
      sh     = lz - 7'd1;
      r.mant = x.mant << sh;
      r.exp  = x.exp - $signed({5'b0, sh});
    end
    return r;
  endfunction

  // exact align, add and one rounding; operands with exp order matching value order
  function automatic logic [31:0] add_core(input xfp_t a, input xfp_t b);
    logic               a_big;
    xfp_t               big;
    xfp_t               sml;
    logic signed [11:0] d;
    logic [63:0]        ms;
    logic [63:0]        sum;
    logic               sgn;
    if (a.nan || b.nan || (a.inf && b.inf && (a.sign != b.sign))) return QNAN;
    if (a.inf) return {a.sign, EXP_MAX, 23'd0};
    if (b.inf) return {b.sign, EXP_MAX, 23'd0};
    a_big = (a.mant != 64'd0) && ((b.mant == 64'd0) || (a.exp > b.exp) ||
            ((a.exp == b.exp) && (a.mant >= b.mant)));
    big = a_big ? a : b;
    sml = a_big ? b : a;
    d   = big.exp - sml.exp;
    ms  = shr_jam(sml.mant, 12'(d));
    sum = (big.sign == sml.sign) ? big.mant + ms : big.mant - ms;
    sgn = (sum == 64'd0) ? (a.sign & b.sign) : big.sign;
    return rnd_pack(sgn, big.exp + 12'sd1, sum);
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] x, input logic [31:0] y);
    return add_core(unpack32(x), unpack32(y));
  endfunction

  function automatic logic [31:0] ftz(input logic [31:0] x);
    return (x[30:23] == 8'd0) ? {x[31], 31'd0} : x;
  endfunction

  // bf16 x bf16 -> fp32, inputs and result flushed, exact otherwise
  function automatic logic [31:0] bmul(input logic [15:0] a, input logic [15:0] w);
    logic               s;
    logic               za;
    logic               zw;
    logic               ia;
    logic               iw;
    logic [15:0]        mp;
    logic signed [10:0] e;
    logic [22:0]        frac;
    s  = a[15] ^ w[15];
    za = (a[14:7] == 8'd0);
    zw = (w[14:7] == 8'd0);
    ia = (a[14:7] == EXP_MAX);
    iw = (w[14:7] == EXP_MAX);
    if ((ia && a[6:0] != 7'd0) || (iw && w[6:0] != 7'd0)) return QNAN;
    if ((ia && zw) || (iw && za)) return QNAN;
    if (ia || iw) return {s, EXP_MAX, 23'd0};
    if (za || zw) return {s, 31'd0};
    mp = {1'b1, a[6:0]} * {1'b1, w[6:0]};
    e  = $signed({3'b0, a[14:7]}) + $signed({3'b0, w[14:7]}) - 11'sd127 +
         $signed({10'b0, mp[15]});
    if (e >= 11'sd255) return {s, EXP_MAX, 23'd0};
    if (e <= 11'sd0) return {s, 31'd0};
    frac = mp[15] ? {mp[14:0], 8'd0} : {mp[13:0], 9'd0};
    return {s, e[7:0], frac};
  endfunction

  // exact fp32 x bf16 product in normalized extended form
  function automatic xfp_t fmul_x(input logic [31:0] t, input logic [15:0] sc);
    xfp_t        r;
    logic        tz;
    logic        sz;
    logic        ti;
    logic        si;
    logic [7:0]  et;
    logic [7:0]  es;
    logic [31:0] p;
    tz = (t[30:0] == 31'd0);
    sz = (sc[14:0] == 15'd0);
    ti = (t[30:23] == EXP_MAX);
    si = (sc[14:7] == EXP_MAX);
    et = (t[30:23] == 8'd0) ? 8'd1 : t[30:23];
    es = (sc[14:7] == 8'd0) ? 8'd1 : sc[14:7];
    p  = {(t[30:23] != 8'd0), t[22:0]} * {(sc[14:7] != 8'd0), sc[6:0]};
    r.sign = t[31] ^ sc[15];
    r.nan  = (ti && t[22:0] != 23'd0) || (si && sc[6:0] != 7'd0) ||
             (ti && sz) || (si && tz);
    r.inf  = ti || si;
    r.exp  = $signed({4'b0, et}) + $signed({4'b0, es}) - 12'sd126;
    r.mant = {1'b0, p, 31'd0};
    return norm62(r);
  endfunction

endpackage
`default_nettype wire

// ----- src/b4gd_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b4gd_lane: one fp32 lane
// Two flushed bf16 products, their flushed pair sum, then a fused multiply by
// the group scale into the lane accumulator with a single rounding.
// ----------------------------------------------------------------------------
module b4gd_lane (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire b4gd_pkg::lane_ctrl_t ctrl,
  input  wire logic [15:0]         act_hi,
  input  wire logic [15:0]         act_lo,
  input  wire logic [15:0]         wt_hi,
  input  wire logic [15:0]         wt_lo,
  input  wire logic [15:0]         scale,
  output logic [31:0]              acc
);

  logic [31:0]         p_hi;
  logic [31:0]         p_lo;
  logic [31:0]         t;
  b4gd_pkg::xfp_t      prod;
  b4gd_pkg::xfp_t      accn;
  logic [31:0]         t_first;

  // products
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      p_hi <= b4gd_pkg::bmul(act_hi, wt_hi);
      p_lo <= b4gd_pkg::bmul(act_lo, wt_lo);
    end
  end

  // zero plus the odd product turns a negative zero positive
  assign t_first = (p_hi == 32'h8000_0000) ? 32'd0 : p_hi;

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      t <= b4gd_pkg::ftz(b4gd_pkg::fadd(t_first, p_lo));
    end
  end

  // exact scale product, accumulator normalized alongside
  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod <= b4gd_pkg::fmul_x(t, scale);
      accn <= b4gd_pkg::norm62(b4gd_pkg::unpack32(acc));
    end
  end

  // accumulate with one rounding
  always_ff @(posedge clk) begin
    if (rst || ctrl.acc_clr) begin
      acc <= 32'd0;
    end else if (ctrl.acc_en) begin
      acc <= b4gd_pkg::add_core(prod, accn);
    end
  end

endmodule
`default_nettype wire

// ----- src/b4gd_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b4gd_merge: lane reduction
// Halving tree over the lane sums, one level per cycle: partners at distance
// 8, 4, 2 and 1, each an fp32 round-to-nearest-even add.
// ----------------------------------------------------------------------------
module b4gd_merge (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] lane_acc [b4gd_pkg::LANES],
  output logic             done,
  output logic [31:0]      result
);

  localparam int HALF = b4gd_pkg::LANES / 2;

  logic [31:0] red [b4gd_pkg::LANES];
  logic [1:0]  lvl;
  logic        busy;

  assign done   = busy && (lvl == 2'(b4gd_pkg::RED_LEVELS - 1));
  assign result = red[0];

  // level counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      lvl  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      lvl  <= '0;
    end else if (busy) begin
      lvl  <= lvl + 2'd1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  // adders: element i takes partner i+8, i+4, i+2, i+1 by level
  for (genvar i = 0; i < b4gd_pkg::LANES; i++) begin : g_red
    if (i < HALF) begin : g_add
      logic [31:0] partner;
      logic        active;
      always_comb begin
        case (lvl)
          2'd0:    partner = red[(i + 8) % b4gd_pkg::LANES];
          2'd1:    partner = red[(i + 4) % b4gd_pkg::LANES];
          2'd2:    partner = red[(i + 2) % b4gd_pkg::LANES];
          default: partner = red[(i + 1) % b4gd_pkg::LANES];
        endcase
      end
      assign active = (32'(i) < (32'(HALF) >> lvl));
      always_ff @(posedge clk) begin
        if (start) begin
          red[i] <= lane_acc[i];
        end else if (busy && active) begin
          red[i] <= b4gd_pkg::fadd(red[i], partner);
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (start) begin
          red[i] <= lane_acc[i];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/bf16_int4_lut_group_dot.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf16_int4_lut_group_dot: bf16 x int4 lookup-table group dot product
// Sixteen fp32 lanes, a sequencer and a reduction tree on a stream interface.
// ----------------------------------------------------------------------------
// A group beat is taken only in the idle state, while the lanes form their
// two bf16 products; the pair sum, scale product and accumulate states
// follow, and no new beat is taken before they end. A tlast beat then passes
// a load state that hands the lane sums to the tree (the lanes clear at once),
// four tree levels and an output state that loads the output register when
// it is free, where the result is held until taken while later groups are
// already accepted. The user must write the weight table through
// cfg_we/cfg_index/cfg_data between beats; the block does not enforce this.
module bf16_int4_lut_group_dot (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [b4gd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [b4gd_pkg::REG_W-1:0]            cfg_data,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // activations_0_3 .. activations_28_31, weight_bytes_0_7, weight_bytes_8_15,
  // group_scale
  input  wire logic [b4gd_pkg::S_DATA_W-1:0]         s_axis_tdata,
  input  wire logic                                  s_axis_tlast,  // last_group
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic [31:0]                                m_axis_tdata   // dot_result
);

  b4gd_pkg::state_t     state;
  b4gd_pkg::state_t     state_next;
  b4gd_pkg::lane_ctrl_t ctrl;
  logic [b4gd_pkg::REG_W-1:0] tbl [b4gd_pkg::NUM_REGS];
  logic [b4gd_pkg::NUM_REGS*b4gd_pkg::REG_W-1:0] tbl_flat;
  logic [15:0]          scale;
  logic                 last;
  logic                 accept;
  logic                 mrg_start;
  logic                 mrg_done;
  logic                 out_load;
  logic [31:0]          mrg_result;
  logic [31:0]          lane_acc [b4gd_pkg::LANES];

  assign accept = s_axis_tvalid && s_axis_tready;

  // weight table registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < b4gd_pkg::NUM_REGS; r++) tbl[r] <= '0;
    end else if (cfg_we) begin
      tbl[cfg_index] <= cfg_data;
    end
  end

  assign tbl_flat = {tbl[3], tbl[2], tbl[1], tbl[0]};

  // per-beat sideband held for the later stages
  always_ff @(posedge clk) begin
    if (accept) begin
      scale <= s_axis_tdata[b4gd_pkg::SCALE_LSB +: 16];
      last  <= s_axis_tlast;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= b4gd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      b4gd_pkg::ST_IDLE: if (accept) state_next = b4gd_pkg::ST_SUM;
      b4gd_pkg::ST_SUM:  state_next = b4gd_pkg::ST_PROD;
      b4gd_pkg::ST_PROD: state_next = b4gd_pkg::ST_ACC;
      b4gd_pkg::ST_ACC:  state_next = last ? b4gd_pkg::ST_LOAD : b4gd_pkg::ST_IDLE;
      b4gd_pkg::ST_LOAD: state_next = b4gd_pkg::ST_RED;
      b4gd_pkg::ST_RED:  if (mrg_done) state_next = b4gd_pkg::ST_OUT;
      b4gd_pkg::ST_OUT:  if (!m_axis_tvalid || m_axis_tready) state_next = b4gd_pkg::ST_IDLE;
      default:           state_next = b4gd_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state == b4gd_pkg::ST_IDLE);
    ctrl.mul_en   = accept;
    ctrl.sum_en   = (state == b4gd_pkg::ST_SUM);
    ctrl.prod_en  = (state == b4gd_pkg::ST_PROD);
    ctrl.acc_en   = (state == b4gd_pkg::ST_ACC);
    ctrl.acc_clr  = (state == b4gd_pkg::ST_LOAD);
    mrg_start     = (state == b4gd_pkg::ST_LOAD);
    out_load      = (state == b4gd_pkg::ST_OUT) && (!m_axis_tvalid || m_axis_tready);
  end

  // lanes: lane i takes elements 2i+1 and 2i
  for (genvar i = 0; i < b4gd_pkg::LANES; i++) begin : g_lane
    logic [b4gd_pkg::CODE_W-1:0] code_hi;
    logic [b4gd_pkg::CODE_W-1:0] code_lo;
    assign code_hi = s_axis_tdata[b4gd_pkg::CODE_LSB + b4gd_pkg::CODE_W*(2*i+1) +: 4];
    assign code_lo = s_axis_tdata[b4gd_pkg::CODE_LSB + b4gd_pkg::CODE_W*(2*i) +: 4];
    b4gd_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .act_hi (s_axis_tdata[b4gd_pkg::ACT_W*(2*i+1) +: 16]),
      .act_lo (s_axis_tdata[b4gd_pkg::ACT_W*(2*i) +: 16]),
      .wt_hi  (tbl_flat[{code_hi, 4'b0000} +: 16]),
      .wt_lo  (tbl_flat[{code_lo, 4'b0000} +: 16]),
      .scale  (scale),
      .acc    (lane_acc[i])
    );
  end

  b4gd_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .start    (mrg_start),
    .lane_acc (lane_acc),
    .done     (mrg_done),
    .result   (mrg_result)
  );

  // output register, NaN made canonical
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= ((mrg_result[30:23] == b4gd_pkg::EXP_MAX) && (mrg_result[22:0] != 23'd0))
                      ? b4gd_pkg::QNAN : mrg_result;
    end
  end

  // checks
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == b4gd_pkg::ST_SUM))
    else $error("accepted beat did not enter the lane pipeline");

  a_done_in_red: assert property (@(posedge clk) disable iff (rst)
    mrg_done |-> (state == b4gd_pkg::ST_RED))
    else $error("reduction finished outside the reduce phase");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == b4gd_pkg::ST_OUT))
    else $error("result raised without a finished reduction");

  a_load_takes: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_axis_tvalid && (state == b4gd_pkg::ST_IDLE)))
    else $error("result load lost");

endmodule
`default_nettype wire

// ----- bench/tb_bf16_int4_lut_group_dot.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bf16_int4_lut_group_dot: stream testbench for the bf16 x int4 group dot
// Drives groups of 32 activations with lookup codes and a scale, predicts the
// fp32 lane accumulation and tree reduction with real arithmetic, and checks
// each dot result in order under random idling and long output back-pressure.
// ----------------------------------------------------------------------------
module tb_bf16_int4_lut_group_dot;
  import b4gd_pkg::*;

  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;

  typedef struct {
    logic [15:0] act[GROUP];
    logic [3:0]  code[GROUP];
    logic [15:0] scale;
    logic        last;
  } group_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [REG_W-1:0]      cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [31:0]           m_axis_tdata;

  // predictor state
  logic [REG_W-1:0] lut_regs[NUM_REGS];
  logic [31:0]      lane_acc[LANES];
  logic [31:0]      dot_queue[$];

  int  errors;
  int  groups_sent;
  int  dots_checked;
  bit  idle_on;
  int  hold_cycles;
  int  stall_left;

  bf16_int4_lut_group_dot u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  // ---- fp helpers on top of real (IEEE double) ----

  function automatic real f32_val(input logic [31:0] b);
    logic [63:0] d;
    if (b[30:23] == 8'hFF) begin
      d = {b[31], 11'h7FF, (b[22:0] != 23'd0) ? 52'h8_0000_0000_0000 : 52'd0};
      return $bitstoreal(d);
    end
    if (b[30:23] == 8'd0)
      return (b[31] ? -1.0 : 1.0) * real'(b[22:0]) * (2.0 ** (-149));
    d = {b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'd0};
    return $bitstoreal(d);
  endfunction

  // double to fp32, round to nearest even, subnormals kept
  function automatic logic [31:0] f32_bits(input real r);
    logic [63:0] d;
    logic [63:0] mm;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] v;
    logic        s;
    logic        inc;
    int          ee;
    int          sh;
    d = $realtobits(r);
    s = d[63];
    if (d[62:52] == 11'h7FF) return (d[51:0] != 52'd0) ? F32_QNAN : {s, 8'hFF, 23'd0};
    if (d[62:52] == 11'd0) return {s, 31'd0};
    ee = int'(d[62:52]) - 1023 + 127;
    if (ee >= 255) return {s, 8'hFF, 23'd0};
    sh = (ee >= 1) ? 29 : 30 - ee;
    if (sh > 54) return {s, 31'd0};
    mm   = {11'd0, 1'b1, d[51:0]};
    kept = mm >> sh;
    rem  = mm & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    inc  = (rem > half) || ((rem == half) && kept[0]);
    v    = ((ee >= 1) ? (32'(ee - 1) << 23) : 32'd0) + kept[31:0] + {31'd0, inc};
    return {s, v[30:0]};
  endfunction

  function automatic bit is_finite(input real r);
    logic [63:0] d;
    d = $realtobits(r);
    return d[62:52] != 11'h7FF;
  endfunction

  // bf16 product: zero-exponent inputs taken as zero, tiny outputs flushed
  function automatic logic [31:0] bf16_prod(input logic [15:0] a, input logic [15:0] w);
    real         p;
    real         tiny;
    logic [63:0] pb;
    tiny = 2.0 ** (-126);
    if (a[14:7] == 8'd0) a = a & 16'h8000;
    if (w[14:7] == 8'd0) w = w & 16'h8000;
    p = f32_val({a, 16'd0}) * f32_val({w, 16'd0});
    pb = $realtobits(p);
    if (is_finite(p) && p != 0.0 && p > -tiny && p < tiny)
      return {pb[63], 31'd0};
    return f32_bits(p);
  endfunction

  function automatic logic [31:0] add_flush(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] s;
    s = f32_bits(f32_val(x) + f32_val(y));
    return (s[30:23] == 8'd0) ? {s[31], 31'd0} : s;
  endfunction

  // single-rounding x*y+z: exact product, round-to-odd sum, then narrow
  function automatic logic [31:0] fma32(input logic [31:0] xb, input logic [31:0] yb,
                                        input logic [31:0] zb);
    real         x;
    real         y;
    real         z;
    real         p;
    real         s;
    real         bb;
    real         err;
    logic [63:0] b;
    x = f32_val(xb);
    y = f32_val(yb);
    z = f32_val(zb);
    p = x * y;
    if (!is_finite(p) || !is_finite(z)) return f32_bits(p + z);
    s   = p + z;
    bb  = s - p;
    err = (p - (s - bb)) + (z - bb);
    b   = $realtobits(s);
    if (err != 0.0 && b[0] == 1'b0) begin
      b = (((err > 0.0) == (s > 0.0))) ? b + 64'd1 : b - 64'd1;
      s = $bitstoreal(b);
    end
    return f32_bits(s);
  endfunction

  // one group into the lanes; pushes the expected dot result on the last group
  task automatic predict_group(input group_t g);
    logic [15:0] wt[GROUP];
    logic [31:0] t;
    logic [31:0] red[LANES];
    for (int n = 0; n < GROUP; n++)
      wt[n] = lut_regs[g.code[n] >> 2][16 * g.code[n][1:0] +: 16];
    for (int i = 0; i < LANES; i++) begin
      t = add_flush(32'd0, bf16_prod(g.act[2*i+1], wt[2*i+1]));
      t = add_flush(t, bf16_prod(g.act[2*i], wt[2*i]));
      lane_acc[i] = fma32(t, {g.scale, 16'd0}, lane_acc[i]);
    end
    if (g.last) begin
      red = lane_acc;
      for (int h = LANES / 2; h >= 1; h /= 2)
        for (int i = 0; i < h; i++)
          red[i] = f32_bits(f32_val(red[i]) + f32_val(red[i+h]));
      dot_queue.push_back(red[0]);
      for (int i = 0; i < LANES; i++) lane_acc[i] = 32'd0;
    end
  endtask

  // ---- drivers ----

  task automatic write_table(input int idx, input logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_IDX_W'(idx);
    cfg_data  = val;
    lut_regs[idx] = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    wait (dot_queue.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // send one group beat; returns just after the accepting edge
  task automatic send_group(input group_t g);
    logic [S_DATA_W-1:0] d;
    int                  gap;
    d = '0;
    for (int n = 0; n < GROUP; n++) begin
      d[ACT_W*n +: ACT_W]             = g.act[n];
      d[CODE_LSB + CODE_W*n +: CODE_W] = g.code[n];
    end
    d[SCALE_LSB +: ACT_W] = g.scale;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = d;
    s_axis_tlast  = g.last;
    do @(posedge clk); while (!s_axis_tready);
    predict_group(g);
    groups_sent++;
  endtask

  task automatic end_burst();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic [15:0] rand_bf16(input int mode);
    logic [15:0] v;
    v = 16'($urandom);
    // mostly moderate exponents so sums stay finite and cancel now and then
    if (mode != 0) v[14:7] = 8'($urandom_range(118, 134));
    return v;
  endfunction

  function automatic group_t rand_group(input int last_odds);
    group_t g;
    int     mode;
    mode = ($urandom_range(0, 9) == 0) ? 0 : 1;
    for (int n = 0; n < GROUP; n++) begin
      g.act[n]  = rand_bf16(mode);
      g.code[n] = 4'($urandom);
    end
    g.scale = rand_bf16(mode);
    g.last  = ($urandom_range(0, last_odds - 1) == 0);
    return g;
  endfunction

  function automatic group_t fill_group(input logic [15:0] a, input logic [3:0] c,
                                        input logic [15:0] sc, input logic last);
    group_t g;
    for (int n = 0; n < GROUP; n++) begin
      g.act[n]  = a;
      g.code[n] = c;
    end
    g.scale = sc;
    g.last  = last;
    return g;
  endfunction

  task automatic load_random_table(input int mode);
    logic [REG_W-1:0] v;
    for (int r = 0; r < NUM_REGS; r++) begin
      for (int k = 0; k < 4; k++) v[16*k +: 16] = rand_bf16(mode);
      write_table(r, v);
    end
  endtask

  // ---- tests ----

  // special table values and field extremes
  task automatic test_directed();
    group_t g;
    write_table(0, {16'hBF80, 16'h3F80, 16'h8000, 16'h0000});  // +0 -0 1 -1
    write_table(1, {16'h7FC1, 16'h7F80, 16'h7F7F, 16'h0001});  // denorm max inf nan
    write_table(2, {16'h3F00, 16'hC000, 16'h8001, 16'h0080});  // min normal, -denorm
    write_table(3, {16'hFF80, 16'h00FF, 16'h4000, 16'h3FC0});
    send_group(fill_group(16'h3F80, 4'd2, 16'h3F80, 1'b1));   // plain ones
    send_group(fill_group(16'h0000, 4'd0, 16'h0000, 1'b1));   // all zero fields
    send_group(fill_group(16'hFFFF, 4'd15, 16'hFFFF, 1'b1));  // all ones fields
    send_group(fill_group(16'h3F80, 4'd4, 16'h3F80, 1'b1));   // denorm weight flushed
    send_group(fill_group(16'h0080, 4'd8, 16'h3F80, 1'b1));   // product below normal
    send_group(fill_group(16'h7F7F, 4'd5, 16'h3F80, 1'b1));   // overflow to inf
    send_group(fill_group(16'h0000, 4'd6, 16'h3F80, 1'b1));   // inf times zero
    send_group(fill_group(16'h3F80, 4'd7, 16'h3F80, 1'b1));   // nan weight
    send_group(fill_group(16'h3F80, 4'd2, 16'h0001, 1'b1));   // subnormal scale
    send_group(fill_group(16'h3F80, 4'd2, 16'h7F80, 1'b1));   // inf scale
    send_group(fill_group(16'h0000, 4'd2, 16'h7F80, 1'b1));   // zero times inf scale
    send_group(fill_group(16'h3F80, 4'd3, 16'h3F80, 1'b0));   // multi-group dot
    send_group(fill_group(16'h3F80, 4'd2, 16'h3F80, 1'b0));
    send_group(fill_group(16'h4000, 4'd9, 16'h3F00, 1'b1));
    for (int k = 0; k < 6; k++) begin
      g = rand_group(2);
      for (int n = 0; n < GROUP; n++) g.code[n] = 4'(n);
      send_group(g);
    end
    send_group(fill_group(16'h3F80, 4'd2, 16'h3F80, 1'b1));
    end_burst();
    wait_drained();
  endtask

  // several tables: all zero, all ones, moderate and fully random
  task automatic test_random_tables(input int per_phase);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: for (int r = 0; r < NUM_REGS; r++) write_table(r, '0);
        1: for (int r = 0; r < NUM_REGS; r++) write_table(r, '1);
        2: load_random_table(1);
        default: load_random_table(0);
      endcase
      for (int k = 0; k < per_phase; k++) send_group(rand_group(4));
      send_group(rand_group(1));
      end_burst();
      wait_drained();
    end
  endtask

  // output held off long enough that the block stalls its input
  task automatic test_backpressure();
    load_random_table(1);
    hold_cycles = 300;
    for (int k = 0; k < 40; k++) send_group(rand_group(2));
    send_group(rand_group(1));
    end_burst();
    wait_drained();
  endtask

  // sender pauses until every dot result is out, then resumes
  task automatic test_pause_resume();
    for (int k = 0; k < 30; k++) begin
      send_group(rand_group(3));
      if (k % 10 == 9) begin
        send_group(rand_group(1));
        end_burst();
        wait (dot_queue.size() == 0);
      end
    end
    send_group(rand_group(1));
    end_burst();
  endtask

  // back-to-back streaming with no idling
  task automatic test_full_rate(input int n_groups);
    idle_on = 1'b0;
    for (int k = 0; k < n_groups; k++) send_group(rand_group(4));
    send_group(rand_group(1));
    end_burst();
  endtask

  // ---- receiver: random stalls plus the long hold-off ----
  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left    = $urandom_range(0, 2);
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (dot_queue.size() == 0) begin
        $error("dot_result unexpected beat: actual %h", m_axis_tdata);
        errors++;
      end else begin
        if (m_axis_tdata !== dot_queue[0]) begin
          $error("dot_result expected %h actual %h", dot_queue[0], m_axis_tdata);
          errors++;
        end
        void'(dot_queue.pop_front());
        dots_checked++;
      end
    end
  end

  initial begin
    errors        = 0;
    groups_sent   = 0;
    dots_checked  = 0;
    idle_on       = 1'b1;
    hold_cycles   = 0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    for (int r = 0; r < NUM_REGS; r++) lut_regs[r] = '0;
    for (int i = 0; i < LANES; i++) lane_acc[i] = 32'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_tables(120);
    test_backpressure();
    test_pause_resume();
    test_full_rate(100);

    wait (dot_queue.size() == 0);
    repeat (30) @(posedge clk);
    $display("tb: %0d groups sent, %0d dot results checked over special, random",
             groups_sent, dots_checked);
    $display("tb: tables, long output hold-off, drain pauses and full-rate streaming");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- bf16_int4_lut_group_dot.f -----
src/b4gd_pkg.sv
src/b4gd_lane.sv
src/b4gd_merge.sv
src/bf16_int4_lut_group_dot.sv
bench/tb_bf16_int4_lut_group_dot.sv
